// ===== rtl/orbit_camera_basis_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Orbit camera basis assertion macros
// Shared concurrent assertion forms for the orbit camera basis RTL.
// ----------------------------------------------------------------------------
`ifndef ORBIT_CAMERA_BASIS_UNIT_ASSERT_SVH
`define ORBIT_CAMERA_BASIS_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OCB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define OCB_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define OCB_ASSERT_IMP(label, clk, rst_n, a, c)
`define OCB_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/ocb_pkg.sv =====
// ----------------------------------------------------------------------------
// Orbit camera basis package
// Types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ocb_pkg;

    localparam logic signed [15:0] ANG_PI      = 16'sd25736;
    localparam logic signed [16:0] ANG_TWO_PI  = 17'sd51472;
    localparam logic signed [15:0] ANG_HALF_PI = 16'sd12868;
    localparam logic signed [15:0] PITCH_LIMIT = 16'sd12725;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam int unsigned        ATAN_DEPTH  = 24;

    typedef enum logic [1:0] {
        MODE_PAN_RIGHT = 2'd0,
        MODE_PAN_UP    = 2'd1,
        MODE_PITCH     = 2'd2,
        MODE_YAW       = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAN,
        ST_ANGLE,
        ST_CORDIC,
        ST_TRIG_DONE,
        ST_BASIS,
        ST_EYE,
        ST_OUT
    } state_t;

    function automatic logic signed [25:0] atan_q24(input logic [4:0] i);
        case (i)
            5'd0:    atan_q24 = 26'sd13176795;
            5'd1:    atan_q24 = 26'sd7778716;
            5'd2:    atan_q24 = 26'sd4110060;
            5'd3:    atan_q24 = 26'sd2086331;
            5'd4:    atan_q24 = 26'sd1047214;
            5'd5:    atan_q24 = 26'sd524117;
            5'd6:    atan_q24 = 26'sd262123;
            5'd7:    atan_q24 = 26'sd131069;
            5'd8:    atan_q24 = 26'sd65536;
            5'd9:    atan_q24 = 26'sd32768;
            5'd10:   atan_q24 = 26'sd16384;
            5'd11:   atan_q24 = 26'sd8192;
            5'd12:   atan_q24 = 26'sd4096;
            5'd13:   atan_q24 = 26'sd2048;
            5'd14:   atan_q24 = 26'sd1024;
            5'd15:   atan_q24 = 26'sd512;
            5'd16:   atan_q24 = 26'sd256;
            5'd17:   atan_q24 = 26'sd128;
            5'd18:   atan_q24 = 26'sd64;
            5'd19:   atan_q24 = 26'sd32;
            5'd20:   atan_q24 = 26'sd16;
            5'd21:   atan_q24 = 26'sd8;
            5'd22:   atan_q24 = 26'sd4;
            5'd23:   atan_q24 = 26'sd2;
            default: atan_q24 = 26'sd0;
        endcase
    endfunction

endpackage

// ===== rtl/orbit_camera_basis_unit.sv =====
// ----------------------------------------------------------------------------
// Orbit camera basis unit
// One event per input beat (pan right, pan up, add pitch, add yaw); one
// result beat with eye position and right, up and backward direction vectors.
// ----------------------------------------------------------------------------
// The event kind travels on s_tuser and its amount on s_tdata. The work
// goes to the single shift-add CORDIC stage, run S = min(CORDIC_STEPS, 24)
// steps for pitch and S for yaw, and to one shared 32x32 multiplier: the
// three pan terms (amount times axis, then radius times that), the four
// basis products and the three eye offsets. s_tready is high only while
// idle and the result beat is held on the master side until taken, so the
// next beat is accepted only after the result of the last one is taken. The
// basis after reset is the zero-angle basis, built by a first pass that
// runs out of reset and produces no result beat.
module orbit_camera_basis_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // amount[15:0]
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata    // eye_x, eye_y, eye_z, right_x..z, up_x..z, dir_x..z
);
    import ocb_pkg::*;
    `include "orbit_camera_basis_unit_assert.svh"

    localparam int STEPS = (CORDIC_STEPS < int'(ATAN_DEPTH)) ? CORDIC_STEPS
                                                             : int'(ATAN_DEPTH);
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    state_t state_reg, state_next;
    logic [30:0] radius_reg;
    logic boot_reg, boot_next;
    logic [1:0] mode_reg;
    logic signed [15:0] amount_reg;
    logic signed [15:0] pitch_reg, pitch_next, yaw_reg, yaw_next;
    logic signed [31:0] tgt_reg [3];
    logic signed [15:0] basis_reg [9];
    logic signed [15:0] cp_reg, sp_reg, cy_reg, sy_reg;
    logic signed [31:0] eye_reg [3];
    logic [3:0]  sub_reg, sub_next;
    logic [4:0]  it_reg, it_next;
    logic        which_reg, which_next;
    logic        flip_reg;
    logic signed [33:0] cx_reg, cy_v_reg;
    logic signed [26:0] cz_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [3:0]  pan_idx, eye_idx;
    logic [1:0]  tgt_idx, eye_wr_idx;

    assign pready = 1'b1;
    assign prdata = {1'b0, radius_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= 31'd65536;
        else if (psel && penable && pwrite && (paddr == 1'b0))
            radius_reg <= pwdata[30:0];
    end

    function automatic logic signed [15:0] clamp_u(input logic signed [63:0] v);
        if (v > 64'sd16384)
            clamp_u = ONE_Q14;
        else if (v < -64'sd16384)
            clamp_u = -ONE_Q14;
        else
            clamp_u = v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    assign mul_p = mul_a * mul_b;

    assign pan_idx    = ((mode_reg == MODE_PAN_UP) ? 4'd3 : 4'd0) + {2'b0, sub_reg[2:1]};
    assign tgt_idx    = sub_reg[2:1] - 2'd1;
    assign eye_idx    = (sub_reg[1:0] == 2'd3) ? 4'd8 : (4'd6 + {2'b0, sub_reg[1:0]});
    assign eye_wr_idx = sub_reg[1:0] - 2'd1;

    // Pan: even sub = amount*axis, odd sub = radius*previous product.
    // Basis: 0..3 = products. Eye: 0..2 = radius*dir.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PAN:
            begin
                if (!sub_reg[0])
                begin
                    mul_a = 32'(amount_reg);
                    mul_b = 32'(basis_reg[pan_idx]);
                end
                else
                begin
                    mul_a = {1'b0, radius_reg};
                    mul_b = prod_reg[31:0];
                end
            end
            ST_BASIS:
            begin
                case (sub_reg)
                    4'd0:
                    begin
                        mul_a = 32'(sp_reg);
                        mul_b = 32'(sy_reg);
                    end
                    4'd1:
                    begin
                        mul_a = 32'(sp_reg);
                        mul_b = 32'(cy_reg);
                    end
                    4'd2:
                    begin
                        mul_a = 32'(cp_reg);
                        mul_b = 32'(sy_reg);
                    end
                    default:
                    begin
                        mul_a = 32'(cp_reg);
                        mul_b = 32'(cy_reg);
                    end
                endcase
            end
            ST_EYE:
            begin
                mul_a = {1'b0, radius_reg};
                mul_b = 32'(basis_reg[eye_idx]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        it_next    = it_reg;
        which_next = which_reg;
        boot_next  = boot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sub_next = '0;
                    if (s_tuser inside {MODE_PAN_RIGHT, MODE_PAN_UP})
                        state_next = ST_PAN;
                    else
                        state_next = ST_ANGLE;
                end
            end
            ST_PAN:
            begin
                sub_next = sub_reg + 4'd1;
                if (sub_reg == 4'd6)
                    state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                it_next = '0;
                which_next = 1'b0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                it_next = it_reg + 5'd1;
                if (it_reg == LAST_STEP)
                    state_next = ST_TRIG_DONE;
            end
            ST_TRIG_DONE:
            begin
                it_next = '0;
                sub_next = '0;
                if (which_reg)
                    state_next = ST_BASIS;
                else
                begin
                    which_next = 1'b1;
                    state_next = ST_CORDIC;
                end
            end
            ST_BASIS:
            begin
                sub_next = sub_reg + 4'd1;
                if (sub_reg == 4'd4)
                begin
                    sub_next = '0;
                    state_next = ST_EYE;
                end
            end
            ST_EYE:
            begin
                sub_next = sub_reg + 4'd1;
                if (sub_reg == 4'd3)
                begin
                    boot_next = 1'b0;
                    state_next = boot_reg ? ST_IDLE : ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !boot_reg;
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb
    begin
        logic signed [16:0] a;
        pitch_next = pitch_reg;
        yaw_next = yaw_reg;
        a = 17'(pitch_reg) + 17'(amount_reg);
        if (mode_reg == MODE_PITCH)
        begin
            if (a < -17'(PITCH_LIMIT))
                pitch_next = -PITCH_LIMIT;
            else if (a > 17'(PITCH_LIMIT))
                pitch_next = PITCH_LIMIT;
            else
                pitch_next = a[15:0];
        end
        a = 17'(yaw_reg) + 17'(amount_reg);
        if (mode_reg == MODE_YAW)
        begin
            if (a < -17'(ANG_PI))
                a = a + ANG_TWO_PI;
            else if (a >= 17'(ANG_PI))
                a = a - ANG_TWO_PI;
            yaw_next = a[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ANGLE;
            sub_reg   <= '0;
            it_reg    <= '0;
            which_reg <= 1'b0;
            boot_reg  <= 1'b1;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            mode_reg  <= MODE_PITCH;
            amount_reg <= '0;
            for (int k = 0; k < 3; k++)
                tgt_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            it_reg    <= it_next;
            which_reg <= which_next;
            boot_reg  <= boot_next;
            if (s_tvalid && s_tready)
            begin
                mode_reg   <= s_tuser;
                amount_reg <= s_tdata;
            end
            if (state_reg == ST_ANGLE)
            begin
                pitch_reg <= pitch_next;
                yaw_reg   <= yaw_next;
            end
            if ((state_reg == ST_PAN) && (sub_reg inside {4'd2, 4'd4, 4'd6}))
                tgt_reg[tgt_idx] <= sat32(64'(tgt_reg[tgt_idx])
                    + ((prod_reg + 64'sd67108864) >>> 27));
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [15:0] ang;
        logic signed [33:0] sx, sy;
        prod_reg <= mul_p;
        if (state_reg == ST_ANGLE || (state_reg == ST_TRIG_DONE && !which_reg))
        begin
            ang = (state_reg == ST_ANGLE) ? pitch_next : yaw_reg;
            flip_reg <= (ang > ANG_HALF_PI) || (ang < -ANG_HALF_PI);
            if (ang > ANG_HALF_PI)
                ang = ang - ANG_PI;
            else if (ang < -ANG_HALF_PI)
                ang = ang + ANG_PI;
            cz_reg <= {ang, 11'd0};
            cx_reg <= CORDIC_START;
            cy_v_reg <= '0;
        end
        if (state_reg == ST_CORDIC)
        begin
            sx = cx_reg >>> it_reg;
            sy = cy_v_reg >>> it_reg;
            if (!cz_reg[26])
            begin
                cx_reg <= cx_reg - sy;
                cy_v_reg <= cy_v_reg + sx;
                cz_reg <= cz_reg - 27'(atan_q24(it_reg));
            end
            else
            begin
                cx_reg <= cx_reg + sy;
                cy_v_reg <= cy_v_reg - sx;
                cz_reg <= cz_reg + 27'(atan_q24(it_reg));
            end
        end
        if (state_reg == ST_TRIG_DONE)
        begin
            sx = flip_reg ? -cx_reg : cx_reg;
            sy = flip_reg ? -cy_v_reg : cy_v_reg;
            if (which_reg)
            begin
                cy_reg <= clamp_u((64'(sx) + 64'sd32768) >>> 16);
                sy_reg <= clamp_u((64'(sy) + 64'sd32768) >>> 16);
            end
            else
            begin
                cp_reg <= clamp_u((64'(sx) + 64'sd32768) >>> 16);
                sp_reg <= clamp_u((64'(sy) + 64'sd32768) >>> 16);
            end
        end
        if (state_reg == ST_BASIS)
        begin
            case (sub_reg)
                4'd0:
                begin
                    basis_reg[0] <= cy_reg;
                    basis_reg[1] <= '0;
                    basis_reg[2] <= sy_reg;
                    basis_reg[4] <= cp_reg;
                    basis_reg[7] <= -sp_reg;
                end
                4'd1: basis_reg[3] <= -clamp_u((prod_reg + 64'sd8192) >>> 14);
                4'd2: basis_reg[5] <= clamp_u((prod_reg + 64'sd8192) >>> 14);
                4'd3: basis_reg[6] <= -clamp_u((prod_reg + 64'sd8192) >>> 14);
                default: basis_reg[8] <= clamp_u((prod_reg + 64'sd8192) >>> 14);
            endcase
        end
        if (state_reg == ST_EYE && sub_reg != 4'd0)
            eye_reg[eye_wr_idx] <= sat32(64'(tgt_reg[eye_wr_idx])
                + ((prod_reg + 64'sd8192) >>> 14));
    end

    assign m_tdata = {basis_reg[8], basis_reg[7], basis_reg[6],
                      basis_reg[5], basis_reg[4], basis_reg[3],
                      basis_reg[2], basis_reg[1], basis_reg[0],
                      eye_reg[2], eye_reg[1], eye_reg[0]};

    `OCB_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `OCB_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !s_tready)
    `OCB_ASSERT_IMP(a_pitch_range, clk, rst_n, 1'b1,
                    pitch_reg <= PITCH_LIMIT && pitch_reg >= -PITCH_LIMIT)
    `OCB_ASSERT_IMP(a_yaw_range, clk, rst_n, 1'b1, yaw_reg < ANG_PI)
endmodule

// ===== dv/tb_orbit_camera_basis_unit.sv =====
// ----------------------------------------------------------------------------
// Orbit camera basis unit testbench
// Drives pan, pitch and yaw events into the slave stream and checks every
// result beat against a local fixed-point camera model. The radius register
// is written over its whole range between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_orbit_camera_basis_unit;
    import ocb_pkg::*;

    localparam int STEPS       = 16;
    localparam int DRAIN_WAIT  = 2 * STEPS + 40;
    localparam int STALL_LIMIT = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [0:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;   // amount[15:0]
    logic [1:0]   s_tuser = '0;   // mode[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;        // eye_x/y/z (32 each), right, up, dir x/y/z (16 each)

    orbit_camera_basis_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

    always #5 clk = ~clk;

    // camera model state
    bit [30:0]    radius_q16 = 31'd65536;
    int           pitch_q13;
    int           yaw_q13;
    int           target_q16 [3];
    int           basis_q14 [9];
    logic [239:0] pending_views [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic int clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return int'(v);
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic void cordic_trig(input int angle, output int c, output int s);
        longint x, y, z, nx;
        bit flip;
        int a;
        x = CORDIC_START;
        y = 0;
        flip = 0;
        a = angle;
        if (a > ANG_HALF_PI)
        begin
            a -= ANG_PI;
            flip = 1;
        end
        else if (a < -ANG_HALF_PI)
        begin
            a += ANG_PI;
            flip = 1;
        end
        z = longint'(a) * 2048;
        for (int i = 0; i < STEPS && i < int'(ATAN_DEPTH); i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_q24(i[4:0]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_q24(i[4:0]);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clamp_unit(round_sh(x, 16));
        s = clamp_unit(round_sh(y, 16));
    endfunction

    function automatic int mul_q14(int a, int b);
        return clamp_unit(round_sh(longint'(a) * b, 14));
    endfunction

    function automatic void rebuild_basis();
        int cp, sp, cy, sy;
        cordic_trig(pitch_q13, cp, sp);
        cordic_trig(yaw_q13, cy, sy);
        basis_q14[0] = cy;
        basis_q14[1] = 0;
        basis_q14[2] = sy;
        basis_q14[3] = -mul_q14(sp, sy);
        basis_q14[4] = cp;
        basis_q14[5] = mul_q14(sp, cy);
        basis_q14[6] = -mul_q14(cp, sy);
        basis_q14[7] = -sp;
        basis_q14[8] = mul_q14(cp, cy);
    endfunction

    function automatic void pan_target(int amount, int base);
        longint ra;
        ra = longint'(radius_q16) * amount;
        for (int k = 0; k < 3; k++)
            target_q16[k] = sat32(longint'(target_q16[k])
                                  + round_sh(ra * basis_q14[base + k], 27));
    endfunction

    function automatic logic [239:0] predict_view(mode_t mode, int amount);
        logic [239:0] v;
        int a;
        case (mode)
            MODE_PAN_RIGHT: pan_target(amount, 0);
            MODE_PAN_UP:    pan_target(amount, 3);
            MODE_PITCH:
            begin
                a = pitch_q13 + amount;
                if (a < -PITCH_LIMIT) a = -PITCH_LIMIT;
                if (a > PITCH_LIMIT) a = PITCH_LIMIT;
                pitch_q13 = a;
            end
            default:
            begin
                a = yaw_q13 + amount;
                if (a < -ANG_PI) a += ANG_TWO_PI;
                else if (a >= ANG_PI) a -= ANG_TWO_PI;
                yaw_q13 = a;
            end
        endcase
        rebuild_basis();
        for (int k = 0; k < 3; k++)
            v[32*k +: 32] = sat32(longint'(target_q16[k])
                                  + round_sh(longint'(radius_q16) * basis_q14[6 + k], 14));
        for (int k = 0; k < 9; k++)
            v[96 + 16*k +: 16] = basis_q14[k][15:0];
        return v;
    endfunction

    function automatic logic [31:0] view_field(logic [239:0] v, int idx);
        if (idx < 3) return v[32*idx +: 32];
        return {16'b0, v[96 + 16*(idx - 3) +: 16]};
    endfunction

    // result checker
    always @(posedge clk)
    begin
        logic [239:0] want;
        if (m_tvalid && m_tready)
        begin
            if (pending_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end
            else
            begin
                want = pending_views.pop_front();
                for (int f = 0; f < 12; f++)
                begin
                    if (view_field(want, f) !== view_field(m_tdata, f))
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d: expected %h, got %h", f,
                                     view_field(want, f), view_field(m_tdata, f));
                    end
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** orbit_camera_basis_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_event(mode_t mode, int amount);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = amount[15:0];
        s_tuser = mode;
        do @(posedge clk); while (!s_tready);
        pending_views.push_back(predict_view(mode, amount));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_radius(logic [31:0] value);
        wait_drained();
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = '0;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        radius_q16 = value[30:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic test_field_extremes();
        send_event(MODE_PAN_RIGHT, 32767);
        send_event(MODE_PAN_RIGHT, -32768);
        send_event(MODE_PAN_UP, 32767);
        send_event(MODE_PAN_UP, -32768);
        send_event(MODE_PAN_UP, 0);
    endtask

    task automatic test_pitch_limit();
        send_event(MODE_PITCH, 32767);
        send_event(MODE_PAN_UP, 8192);
        send_event(MODE_PITCH, -32768);
        send_event(MODE_PITCH, 12725);
        send_event(MODE_PITCH, -1);
    endtask

    task automatic test_yaw_wrap();
        send_event(MODE_YAW, 25736);
        send_event(MODE_YAW, -1);
        send_event(MODE_YAW, 32767);
        send_event(MODE_YAW, -32768);
        send_event(MODE_YAW, 12869);
        send_event(MODE_PAN_RIGHT, 4096);
    endtask

    task automatic test_radius_extremes();
        write_radius(32'h7fffffff);
        send_event(MODE_PAN_RIGHT, 32767);
        send_event(MODE_PAN_RIGHT, 32767);
        send_event(MODE_PAN_UP, -32768);
        write_radius(32'd0);
        send_event(MODE_PAN_RIGHT, 32767);
        send_event(MODE_YAW, 5000);
        write_radius(32'hffffffff);
        send_event(MODE_PAN_UP, -32768);
        write_radius(32'd1);
        send_event(MODE_PAN_RIGHT, -32768);
    endtask

    task automatic test_random_events(int count, logic [31:0] radius);
        int amount;
        write_radius(radius);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
                amount = $signed($urandom_range(65535) - 32768);
            else
                amount = $signed($urandom_range(4095)) - 2048;
            send_event(mode_t'($urandom_range(3)), amount);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        pitch_q13 = 0;
        yaw_q13 = 0;
        for (int k = 0; k < 3; k++) target_q16[k] = 0;
        rebuild_basis();

        test_field_extremes();
        test_pitch_limit();
        test_yaw_wrap();
        test_radius_extremes();

        send_idle_pct = 9;
        recv_stall_pct = 75;
        test_random_events(480, 32'd65536);
        send_idle_pct = 75;
        recv_stall_pct = 9;
        test_random_events(480, $urandom());
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_events(240, 32'd200000);
        test_random_events(240, $urandom_range(65535));

        wait_drained();
        if (mismatches == 0)
            $display("** orbit_camera_basis_unit: PASSED **");
        else
            $display("** orbit_camera_basis_unit: FAILED **");
        $finish;
    end
endmodule
